FILE: src/aggt_pkg.sv
package aggt_pkg;

  localparam int MaxLen    = 256;
  localparam int Alphabet  = 32;
  localparam int ScoreBits = 24;

  localparam int LenW      = $clog2(MaxLen + 1);
  localparam int IdxW      = $clog2(MaxLen);
  localparam int ColDepth  = MaxLen + 1;
  localparam int MoveDepth = MaxLen * MaxLen;
  localparam int PairDepth = 2 * MaxLen;
  localparam int PairIdxW  = $clog2(PairDepth);
  localparam int PairW     = $clog2(PairDepth + 1);
  localparam int SymW      = $clog2(Alphabet);
  localparam int TabDepth  = Alphabet * Alphabet;
  localparam int PackW     = 2 * SymW + 2;
  localparam int WideW     = ScoreBits + 2;

  // input kinds
  localparam logic [2:0] KindLoad   = 3'd0;
  localparam logic [2:0] KindAppA   = 3'd1;
  localparam logic [2:0] KindAppB   = 3'd2;
  localparam logic [2:0] KindAlign  = 3'd3;
  localparam logic [2:0] KindFetch  = 3'd4;
  localparam logic [2:0] KindClear  = 3'd5;

  // result status
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatDrop   = 2'd1;
  localparam logic [1:0] StatNone   = 2'd2;

  // traceback moves
  localparam logic [1:0] MvDiag     = 2'd0;
  localparam logic [1:0] MvAgap     = 2'd1;
  localparam logic [1:0] MvBgap     = 2'd2;

  // configuration register indexes
  localparam logic CfgOpen          = 1'b0;
  localparam logic CfgExt           = 1'b1;

  typedef logic signed [ScoreBits-1:0] score_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [4:0]        symbol;
    logic [4:0]        table_row;
    logic [4:0]        table_col;
    logic signed [7:0] table_score;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] score;
    logic [9:0]         pair_total;
    logic [4:0]         a_symbol;
    logic               a_gap;
    logic [4:0]         b_symbol;
    logic               b_gap;
    logic               last_pair;
  } out_item_t;

  typedef struct packed {
    score_t            mup;
    score_t            ia_up;
    score_t            best;
    score_t            vgap;
    score_t            diag;
    logic signed [7:0] subst;
    logic [7:0]        gap_open;
    logic [7:0]        gap_ext;
  } cell_in_t;

  typedef struct packed {
    score_t     m;
    score_t     g;
    score_t     h;
    logic [1:0] mv;
  } cell_out_t;

  function automatic score_t sat_wide(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'((64'sd1 <<< (ScoreBits - 1)) - 64'sd1);
    lo = -hi - WideW'(1);
    if (v > hi) return hi[ScoreBits-1:0];
    if (v < lo) return lo[ScoreBits-1:0];
    return v[ScoreBits-1:0];
  endfunction

  function automatic score_t sat_sub(input score_t a, input logic [7:0] b);
    logic signed [WideW-1:0] t;
    t = WideW'(a) - $signed({{(WideW-8){1'b0}}, b});
    return sat_wide(t);
  endfunction

  function automatic score_t sat_add(input score_t a, input logic signed [7:0] b);
    logic signed [WideW-1:0] t;
    t = WideW'(a) + WideW'(b);
    return sat_wide(t);
  endfunction

endpackage

FILE: src/affine_gap_global_alignment_core.sv
// Affine-gap global alignment engine.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one transaction at a
// time: table loads, symbol appends to A or B, align, fetch and clear.
// Output channel (out_valid_o/out_ready_i, out_data_o) returns one result for
// align and fetch transactions; other kinds give none.
// Config channel (cfg_valid_i/cfg_ready_o) writes gap_open (index 0) and
// gap_extend (index 1); it is always ready and must only be used when idle.
// Load, append and clear are taken in the idle state; fetch reads the pair
// memory, then builds its result. Align writes the boundary column; for each
// grid cell it reads the column memory and B symbol, then the substitution
// table, then writes the column and move memories. Traceback per pair
// reads the move memory, then writes the pair. Table, sequences, column,
// moves and pairs live in single-port-write, registered-read memories; the
// grid column and the move array are updated in place, one cell at a time.
// Reset clears counters, the pair list, the drop flag and restores gap_open=10
// and gap_extend=1; memory contents are left as they are.
// A finished result sits in the output register; while the receiver stalls,
// load/append/clear transactions are still taken, and the next result
// producing transaction holds in its final state until the register frees.
module affine_gap_global_alignment_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aggt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aggt_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  localparam int LenW  = aggt_pkg::LenW;
  localparam int IdxW  = aggt_pkg::IdxW;
  localparam int PairW = aggt_pkg::PairW;
  localparam int SymW  = aggt_pkg::SymW;
  localparam int SB    = aggt_pkg::ScoreBits;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StCol   = 4'd2;
  localparam logic [3:0] StC0    = 4'd3;
  localparam logic [3:0] StC1    = 4'd4;
  localparam logic [3:0] StC2    = 4'd5;
  localparam logic [3:0] StColEnd = 4'd6;
  localparam logic [3:0] StRes   = 4'd7;
  localparam logic [3:0] StRes2  = 4'd8;
  localparam logic [3:0] StTb0   = 4'd9;
  localparam logic [3:0] StTb1   = 4'd10;
  localparam logic [3:0] StFetch = 4'd11;
  localparam logic [3:0] StDone  = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [7:0]       open_q, ext_q;
  logic [LenW-1:0]  a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [LenW-1:0]  ci_q, ci_d, cj_q, cj_d;
  logic [PairW-1:0] pc_q, pc_d, fp_q, fp_d, n_q, n_d;
  logic             drop_q, drop_d;
  aggt_pkg::score_t ei_q, ei_d, ej_q, ej_d, diag_q, diag_d;
  aggt_pkg::score_t mup_q, mup_d, iaup_q, iaup_d, score_q, score_d;
  aggt_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // memory ports
  logic                         tab_we;
  logic [$clog2(aggt_pkg::TabDepth)-1:0] tab_waddr, tab_raddr;
  logic [7:0]                   tab_rdata;
  logic                         tab_re;
  logic                         sa_we, sa_re, sb_we, sb_re;
  logic [IdxW-1:0]              sa_waddr, sa_raddr, sb_waddr, sb_raddr;
  logic [SymW-1:0]              sa_rdata, sb_rdata;
  logic                         col_we, col_re;
  logic [$clog2(aggt_pkg::ColDepth)-1:0] col_waddr, col_raddr;
  logic [2*SB-1:0]              col_wdata, col_rdata;
  logic                         mv_we, mv_re;
  logic [$clog2(aggt_pkg::MoveDepth)-1:0] mv_waddr, mv_raddr;
  logic [1:0]                   mv_wdata, mv_rdata;
  logic                         pr_we, pr_re;
  logic [aggt_pkg::PairIdxW-1:0] pr_waddr, pr_raddr;
  logic [aggt_pkg::PackW-1:0]   pr_wdata, pr_rdata;

  aggt_pkg::cell_in_t  cell_in;
  aggt_pkg::cell_out_t cell_out;

  logic [IdxW-1:0]  im1, jm1;
  logic [PairW-1:0] fidx;
  logic [1:0]       tb_mv;
  logic             res_free;
  logic             in_fire;

  assign im1      = IdxW'(ci_q - LenW'(1));
  assign jm1      = IdxW'(cj_q - LenW'(1));
  assign fidx     = pc_q - PairW'(1) - fp_q;
  assign res_free = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cell_in.mup      = mup_q;
    cell_in.ia_up    = iaup_q;
    cell_in.best     = col_rdata[2*SB-1:SB];
    cell_in.vgap     = col_rdata[SB-1:0];
    cell_in.diag     = diag_q;
    cell_in.subst    = tab_rdata;
    cell_in.gap_open = open_q;
    cell_in.gap_ext  = ext_q;
  end

  aggt_cell u_cell (
    .cell_i (cell_in),
    .cell_o (cell_out)
  );

  always_comb begin
    if (ci_q != '0 && cj_q != '0) begin
      tb_mv = mv_rdata;
    end else if (ci_q != '0) begin
      tb_mv = aggt_pkg::MvBgap;
    end else begin
      tb_mv = aggt_pkg::MvAgap;
    end
  end

  always_comb begin
    state_d     = state_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    ci_d        = ci_q;
    cj_d        = cj_q;
    pc_d        = pc_q;
    fp_d        = fp_q;
    n_d         = n_q;
    drop_d      = drop_q;
    ei_d        = ei_q;
    ej_d        = ej_q;
    diag_d      = diag_q;
    mup_d       = mup_q;
    iaup_d      = iaup_q;
    score_d     = score_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    tab_we    = 1'b0;
    tab_waddr = {in_data_i.table_row, in_data_i.table_col};
    tab_re    = 1'b0;
    tab_raddr = {sa_rdata, sb_rdata};
    sa_we     = 1'b0;
    sa_waddr  = a_cnt_q[IdxW-1:0];
    sa_re     = 1'b0;
    sa_raddr  = im1;
    sb_we     = 1'b0;
    sb_waddr  = b_cnt_q[IdxW-1:0];
    sb_re     = 1'b0;
    sb_raddr  = jm1;
    col_we    = 1'b0;
    col_waddr = cj_q;
    col_wdata = {ej_q, aggt_pkg::sat_sub(ej_q, open_q)};
    col_re    = 1'b0;
    col_raddr = cj_q;
    mv_we     = 1'b0;
    mv_waddr  = {im1, jm1};
    mv_wdata  = cell_out.mv;
    mv_re     = 1'b0;
    mv_raddr  = {im1, jm1};
    pr_we     = 1'b0;
    pr_waddr  = n_q[aggt_pkg::PairIdxW-1:0];
    pr_wdata  = '0;
    pr_re     = 1'b0;
    pr_raddr  = fidx[aggt_pkg::PairIdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (in_data_i.kind)
            aggt_pkg::KindLoad: tab_we = 1'b1;
            aggt_pkg::KindAppA: begin
              if (a_cnt_q < LenW'(aggt_pkg::MaxLen)) begin
                sa_we   = 1'b1;
                a_cnt_d = a_cnt_q + LenW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            aggt_pkg::KindAppB: begin
              if (b_cnt_q < LenW'(aggt_pkg::MaxLen)) begin
                sb_we   = 1'b1;
                b_cnt_d = b_cnt_q + LenW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            aggt_pkg::KindAlign: begin
              cj_d    = '0;
              ej_d    = aggt_pkg::sat_sub('0, open_q);
              state_d = StInit;
            end
            aggt_pkg::KindFetch: begin
              if (fp_q < pc_q) begin
                pr_re   = 1'b1;
                state_d = StFetch;
              end else begin
                res_d        = '0;
                res_d.status = aggt_pkg::StatNone;
                state_d      = StDone;
              end
            end
            aggt_pkg::KindClear: begin
              a_cnt_d = '0;
              b_cnt_d = '0;
              pc_d    = '0;
              fp_d    = '0;
              drop_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StInit: begin
        // write the boundary column, row by row
        col_we = 1'b1;
        if (cj_q == '0) begin
          col_wdata = '0;
        end else begin
          ej_d = aggt_pkg::sat_sub(ej_q, ext_q);
        end
        if (cj_q == b_cnt_q) begin
          ci_d   = LenW'(1);
          ei_d   = aggt_pkg::sat_sub('0, open_q);
          diag_d = '0;
          state_d = (a_cnt_q == '0) ? StRes : StCol;
        end else begin
          cj_d = cj_q + LenW'(1);
        end
      end
      StCol: begin
        sa_re     = 1'b1;
        col_we    = 1'b1;
        col_waddr = '0;
        col_wdata = {ei_q, aggt_pkg::sat_sub(ei_q, open_q)};
        mup_d     = ei_q;
        iaup_d    = aggt_pkg::sat_sub(ei_q, open_q);
        cj_d      = LenW'(1);
        state_d   = (b_cnt_q == '0) ? StColEnd : StC0;
      end
      StC0: begin
        col_re  = 1'b1;
        sb_re   = 1'b1;
        state_d = StC1;
      end
      StC1: begin
        tab_re  = 1'b1;
        state_d = StC2;
      end
      StC2: begin
        col_we    = 1'b1;
        col_wdata = {cell_out.m, cell_out.h};
        mv_we     = 1'b1;
        diag_d    = col_rdata[2*SB-1:SB];
        mup_d     = cell_out.m;
        iaup_d    = cell_out.g;
        if (cj_q == b_cnt_q) begin
          state_d = StColEnd;
        end else begin
          cj_d    = cj_q + LenW'(1);
          state_d = StC0;
        end
      end
      StColEnd: begin
        diag_d = ei_q;
        ei_d   = aggt_pkg::sat_sub(ei_q, ext_q);
        if (ci_q == a_cnt_q) begin
          state_d = StRes;
        end else begin
          ci_d    = ci_q + LenW'(1);
          state_d = StCol;
        end
      end
      StRes: begin
        col_re    = 1'b1;
        col_raddr = b_cnt_q;
        state_d   = StRes2;
      end
      StRes2: begin
        score_d = col_rdata[2*SB-1:SB];
        ci_d    = a_cnt_q;
        cj_d    = b_cnt_q;
        n_d     = '0;
        state_d = StTb0;
      end
      StTb0: begin
        if (ci_q == '0 && cj_q == '0) begin
          pc_d             = n_q;
          fp_d             = '0;
          res_d            = '0;
          res_d.status     = drop_q ? aggt_pkg::StatDrop : aggt_pkg::StatOk;
          res_d.score      = score_q;
          res_d.pair_total = n_q;
          state_d          = StDone;
        end else begin
          mv_re   = (ci_q != '0) && (cj_q != '0);
          sa_re   = (ci_q != '0);
          sb_re   = (cj_q != '0);
          state_d = StTb1;
        end
      end
      StTb1: begin
        // pairs go in traceback order; fetch reads them from the far end
        pr_we = 1'b1;
        n_d   = n_q + PairW'(1);
        case (tb_mv)
          aggt_pkg::MvDiag: begin
            pr_wdata = {1'b0, sb_rdata, 1'b0, sa_rdata};
            ci_d     = ci_q - LenW'(1);
            cj_d     = cj_q - LenW'(1);
          end
          aggt_pkg::MvAgap: begin
            pr_wdata = {1'b0, sb_rdata, 1'b1, {SymW{1'b0}}};
            cj_d     = cj_q - LenW'(1);
          end
          default: begin
            pr_wdata = {1'b1, {SymW{1'b0}}, 1'b0, sa_rdata};
            ci_d     = ci_q - LenW'(1);
          end
        endcase
        state_d = StTb0;
      end
      StFetch: begin
        res_d            = '0;
        res_d.status     = aggt_pkg::StatOk;
        res_d.pair_total = pc_q;
        res_d.a_symbol   = pr_rdata[SymW-1:0];
        res_d.a_gap      = pr_rdata[SymW];
        res_d.b_symbol   = pr_rdata[2*SymW:SymW+1];
        res_d.b_gap      = pr_rdata[2*SymW+1];
        res_d.last_pair  = (fp_q + PairW'(1) == pc_q);
        fp_d             = fp_q + PairW'(1);
        state_d          = StDone;
      end
      StDone: begin
        // hold until the output register frees
        if (res_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      open_q      <= 8'd10;
      ext_q       <= 8'd1;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      pc_q        <= '0;
      fp_q        <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      pc_q        <= pc_d;
      fp_q        <= fp_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == aggt_pkg::CfgOpen) begin
          open_q <= cfg_data_i;
        end else begin
          ext_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ci_q    <= ci_d;
    cj_q    <= cj_d;
    n_q     <= n_d;
    ei_q    <= ei_d;
    ej_q    <= ej_d;
    diag_q  <= diag_d;
    mup_q   <= mup_d;
    iaup_q  <= iaup_d;
    score_q <= score_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  aggt_ram #(.Width(8), .Depth(aggt_pkg::TabDepth)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(in_data_i.table_score),
    .re_i(tab_re), .raddr_i(tab_raddr), .rdata_o(tab_rdata)
  );

  aggt_ram #(.Width(SymW), .Depth(aggt_pkg::MaxLen)) u_seq_a (
    .clk_i, .we_i(sa_we), .waddr_i(sa_waddr), .wdata_i(in_data_i.symbol),
    .re_i(sa_re), .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );

  aggt_ram #(.Width(SymW), .Depth(aggt_pkg::MaxLen)) u_seq_b (
    .clk_i, .we_i(sb_we), .waddr_i(sb_waddr), .wdata_i(in_data_i.symbol),
    .re_i(sb_re), .raddr_i(sb_raddr), .rdata_o(sb_rdata)
  );

  aggt_ram #(.Width(2*SB), .Depth(aggt_pkg::ColDepth)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .re_i(col_re), .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  aggt_ram #(.Width(2), .Depth(aggt_pkg::MoveDepth)) u_move (
    .clk_i, .we_i(mv_we), .waddr_i(mv_waddr), .wdata_i(mv_wdata),
    .re_i(mv_re), .raddr_i(mv_raddr), .rdata_o(mv_rdata)
  );

  aggt_ram #(.Width(aggt_pkg::PackW), .Depth(aggt_pkg::PairDepth)) u_pair (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(pr_wdata),
    .re_i(pr_re), .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );

  a_seq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= LenW'(aggt_pkg::MaxLen) && b_cnt_q <= LenW'(aggt_pkg::MaxLen))
    else $error("sequence count beyond capacity");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fp_q <= pc_q)
    else $error("fetch pointer passed pair count");

  a_cell_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StC2) |-> (cj_q != '0 && cj_q <= b_cnt_q && ci_q != '0))
    else $error("cell update outside the grid");

  a_tb_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTb1) |-> (n_q < PairW'(aggt_pkg::PairDepth)))
    else $error("traceback overflows pair buffer");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && res_free) |=> (out_valid_q && state_q == StIdle))
    else $error("result not loaded into output register");

endmodule

FILE: src/aggt_ram.sv
module aggt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/aggt_cell.sv
module aggt_cell (
  input  aggt_pkg::cell_in_t  cell_i,
  output aggt_pkg::cell_out_t cell_o
);

  aggt_pkg::score_t a1, a2, b1, b2, g, h, f;

  always_comb begin
    a1 = aggt_pkg::sat_sub(cell_i.mup, cell_i.gap_open);
    a2 = aggt_pkg::sat_sub(cell_i.ia_up, cell_i.gap_ext);
    g  = (a1 >= a2) ? a1 : a2;
    b1 = aggt_pkg::sat_sub(cell_i.best, cell_i.gap_open);
    b2 = aggt_pkg::sat_sub(cell_i.vgap, cell_i.gap_ext);
    h  = (b1 >= b2) ? b1 : b2;
    f  = aggt_pkg::sat_add(cell_i.diag, cell_i.subst);
    cell_o.g = g;
    cell_o.h = h;
    // diagonal wins ties, then the B-gap move
    if (f >= g && f >= h) begin
      cell_o.m  = f;
      cell_o.mv = aggt_pkg::MvDiag;
    end else if (g > h) begin
      cell_o.m  = g;
      cell_o.mv = aggt_pkg::MvAgap;
    end else begin
      cell_o.m  = h;
      cell_o.mv = aggt_pkg::MvBgap;
    end
  end

endmodule

FILE: dv/affine_gap_global_alignment_core_tb.sv
module affine_gap_global_alignment_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CycleLimit = 200000;
  localparam int  HoldCycles = 300;
  localparam int  IdlePct    = 17;
  // Finishing cycles for the last no-result transaction before going idle.
  localparam int  SettleCycles = 12;
  localparam int  InW        = $bits(aggt_pkg::in_item_t);
  localparam longint ScoreHi = (64'sd1 <<< (aggt_pkg::ScoreBits - 1)) - 1;
  localparam longint ScoreLo = -ScoreHi - 1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  aggt_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  aggt_pkg::out_item_t out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [7:0]          cfg_data_i;

  affine_gap_global_alignment_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the engine state, updated on every accepted transaction
  // ---------------------------------------------------------------------
  longint      subst_sh [aggt_pkg::TabDepth];
  logic [4:0]  seq_a_sh [aggt_pkg::MaxLen];
  logic [4:0]  seq_b_sh [aggt_pkg::MaxLen];
  int          len_a, len_b;
  logic [1:0]  move_sh  [aggt_pkg::MoveDepth];
  logic [11:0] aligned_pairs[$];
  int          fetch_idx;
  bit          drop_seen;
  int          open_pen, ext_pen;

  aggt_pkg::out_item_t pending_results[$];
  int          errors;
  int          in_accepts;
  bit          typed_valid;
  aggt_pkg::out_item_t typed_want;
  bit          hold_req;
  bit          calm;
  longint      cycles;

  function automatic longint clip(longint v);
    if (v > ScoreHi) return ScoreHi;
    if (v < ScoreLo) return ScoreLo;
    return v;
  endfunction

  function automatic longint border_score(int k);
    return clip(-longint'(open_pen) - longint'(k - 1) * longint'(ext_pen));
  endfunction

  // Symbols used by the stimulus; the start-up loads cover their table entries.
  function automatic logic [4:0] set_sym(int k);
    case (k)
      0:       return 5'd0;
      1:       return 5'd3;
      2:       return 5'd21;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [4:0] pick_sym();
    return set_sym(int'($urandom_range(3)));
  endfunction

  // Fill the grid column by column, then walk the stored moves back.
  function automatic longint align_grid();
    longint best [aggt_pkg::MaxLen + 1];
    longint vgap [aggt_pkg::MaxLen + 1];
    longint diag, mup, ia_up, g, h, f, m, c1, c2;
    logic [1:0] mv;
    int i, j;
    best[0] = 0;
    vgap[0] = 0;
    for (j = 1; j <= len_b; j++) begin
      best[j] = border_score(j);
      vgap[j] = clip(best[j] - open_pen);
    end
    for (i = 1; i <= len_a; i++) begin
      diag    = best[0];
      mup     = border_score(i);
      ia_up   = clip(mup - open_pen);
      best[0] = mup;
      vgap[0] = ia_up;
      for (j = 1; j <= len_b; j++) begin
        c1 = clip(mup - open_pen);
        c2 = clip(ia_up - ext_pen);
        g  = (c1 >= c2) ? c1 : c2;
        c1 = clip(best[j] - open_pen);
        c2 = clip(vgap[j] - ext_pen);
        h  = (c1 >= c2) ? c1 : c2;
        f  = clip(diag + subst_sh[{seq_a_sh[i-1], seq_b_sh[j-1]}]);
        // diagonal wins ties; B-gap wins unless A-gap is strictly larger
        if (f >= g && f >= h) begin
          m = f; mv = aggt_pkg::MvDiag;
        end else if (g > h) begin
          m = g; mv = aggt_pkg::MvAgap;
        end else begin
          m = h; mv = aggt_pkg::MvBgap;
        end
        diag    = best[j];
        best[j] = m;
        vgap[j] = h;
        move_sh[(i-1)*aggt_pkg::MaxLen + (j-1)] = mv;
        mup   = m;
        ia_up = g;
      end
    end
    // Traceback runs backward, so prepend to get forward order.
    aligned_pairs.delete();
    i = len_a;
    j = len_b;
    while (i > 0 && j > 0) begin
      mv = move_sh[(i-1)*aggt_pkg::MaxLen + (j-1)];
      if (mv == aggt_pkg::MvDiag) begin
        aligned_pairs.push_front({1'b0, seq_b_sh[j-1], 1'b0, seq_a_sh[i-1]});
        i--; j--;
      end else if (mv == aggt_pkg::MvAgap) begin
        aligned_pairs.push_front({1'b0, seq_b_sh[j-1], 1'b1, 5'd0});
        j--;
      end else begin
        aligned_pairs.push_front({1'b1, 5'd0, 1'b0, seq_a_sh[i-1]});
        i--;
      end
    end
    while (i > 0) begin
      aligned_pairs.push_front({1'b1, 5'd0, 1'b0, seq_a_sh[i-1]});
      i--;
    end
    while (j > 0) begin
      aligned_pairs.push_front({1'b0, seq_b_sh[j-1], 1'b1, 5'd0});
      j--;
    end
    fetch_idx = 0;
    return best[len_b];
  endfunction

  // Advance the shadow state by one transaction; return 1 with the result
  // when the transaction produces one.
  function automatic bit predict_alignment_step(input aggt_pkg::in_item_t it,
                                                output aggt_pkg::out_item_t res);
    longint s;
    logic [11:0] p;
    res = '0;
    case (it.kind)
      aggt_pkg::KindLoad: begin
        subst_sh[{it.table_row, it.table_col}] = longint'(it.table_score);
        return 1'b0;
      end
      aggt_pkg::KindAppA: begin
        if (len_a < aggt_pkg::MaxLen) begin
          seq_a_sh[len_a] = it.symbol;
          len_a++;
        end else begin
          drop_seen = 1'b1;
        end
        return 1'b0;
      end
      aggt_pkg::KindAppB: begin
        if (len_b < aggt_pkg::MaxLen) begin
          seq_b_sh[len_b] = it.symbol;
          len_b++;
        end else begin
          drop_seen = 1'b1;
        end
        return 1'b0;
      end
      aggt_pkg::KindAlign: begin
        s = align_grid();
        res.status     = drop_seen ? aggt_pkg::StatDrop : aggt_pkg::StatOk;
        res.score      = s[23:0];
        res.pair_total = 10'(aligned_pairs.size());
        return 1'b1;
      end
      aggt_pkg::KindFetch: begin
        if (fetch_idx < aligned_pairs.size()) begin
          p = aligned_pairs[fetch_idx];
          res.pair_total = 10'(aligned_pairs.size());
          res.a_symbol   = p[4:0];
          res.a_gap      = p[5];
          res.b_symbol   = p[10:6];
          res.b_gap      = p[11];
          fetch_idx++;
          res.last_pair  = (fetch_idx == aligned_pairs.size());
        end else begin
          res.status = aggt_pkg::StatNone;
        end
        return 1'b1;
      end
      aggt_pkg::KindClear: begin
        len_a = 0;
        len_b = 0;
        aligned_pairs.delete();
        fetch_idx = 0;
        drop_seen = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Monitors: sample at the rising edge, inputs only move at the falling one
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    aggt_pkg::out_item_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (predict_alignment_step(in_data_i, r)) begin
        // a typed-in expectation overrides the predicted one
        pending_results.push_back(typed_valid ? typed_want : r);
      end
      in_accepts++;
    end
  end

  always @(posedge clk_i) begin
    aggt_pkg::out_item_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_data_o.status !== w.status) begin
          $display("%0t: status exp %0d act %0d", $time, w.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.score !== w.score) begin
          $display("%0t: score exp %0d act %0d", $time, w.score, out_data_o.score);
          errors++;
        end
        if (out_data_o.pair_total !== w.pair_total) begin
          $display("%0t: pair_total exp %0d act %0d", $time, w.pair_total,
                   out_data_o.pair_total);
          errors++;
        end
        if (out_data_o.a_symbol !== w.a_symbol || out_data_o.a_gap !== w.a_gap) begin
          $display("%0t: A side exp %0d/%0b act %0d/%0b", $time, w.a_symbol, w.a_gap,
                   out_data_o.a_symbol, out_data_o.a_gap);
          errors++;
        end
        if (out_data_o.b_symbol !== w.b_symbol || out_data_o.b_gap !== w.b_gap) begin
          $display("%0t: B side exp %0d/%0b act %0d/%0b", $time, w.b_symbol, w.b_gap,
                   out_data_o.b_symbol, out_data_o.b_gap);
          errors++;
        end
        if (out_data_o.last_pair !== w.last_pair) begin
          $display("%0t: last_pair exp %0b act %0b", $time, w.last_pair,
                   out_data_o.last_pair);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int k;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // starve the output so the result register and the input back up
        out_ready_i <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < IdlePct) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  // Offer one transaction at the falling edge, hold until it is taken.
  task automatic send_item(input aggt_pkg::in_item_t it);
    int target;
    if (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    target = in_accepts + 1;
    wait (in_accepts == target);
    @(negedge clk_i);
  endtask

  function automatic aggt_pkg::in_item_t make_item(logic [2:0] k, logic [4:0] sym);
    aggt_pkg::in_item_t it;
    it             = aggt_pkg::in_item_t'(InW'($urandom));
    it.kind        = k;
    it.symbol      = sym;
    return it;
  endfunction

  task automatic quiesce();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_gap_reg(input logic idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == aggt_pkg::CfgOpen) open_pen = val;
    else                          ext_pen  = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed run: clear, fill both sequences, align, drain every pair
  // and one fetch past the end.
  task automatic run_alignment(input int na, input int nb);
    int n;
    send_item(make_item(aggt_pkg::KindClear, 5'd0));
    for (n = 0; n < na; n++) send_item(make_item(aggt_pkg::KindAppA, pick_sym()));
    for (n = 0; n < nb; n++) send_item(make_item(aggt_pkg::KindAppB, pick_sym()));
    send_item(make_item(aggt_pkg::KindAlign, 5'd0));
    while (fetch_idx < aligned_pairs.size()) begin
      send_item(make_item(aggt_pkg::KindFetch, 5'd0));
    end
    send_item(make_item(aggt_pkg::KindFetch, 5'd0));
  endtask

  // Noise: any kind with random content, including reserved kinds; appended
  // symbols stay within the loaded part of the table.
  task automatic send_noise();
    aggt_pkg::in_item_t it;
    it = aggt_pkg::in_item_t'(InW'($urandom));
    if (it.kind == aggt_pkg::KindClear && $urandom_range(1)) it.kind = aggt_pkg::KindFetch;
    if (it.kind == aggt_pkg::KindAppA || it.kind == aggt_pkg::KindAppB) begin
      it.symbol = pick_sym();
    end
    send_item(it);
  endtask

  typedef struct {
    aggt_pkg::in_item_t  item;
    bit                  typed;
    aggt_pkg::out_item_t want;
  } dir_row_t;

  initial begin
    dir_row_t   rows[$];
    dir_row_t   r;
    aggt_pkg::out_item_t none_res;
    aggt_pkg::out_item_t empty_res;
    int         n, ph, ra, ca;
    logic [7:0] open_set [6];
    logic [7:0] ext_set  [6];

    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = aggt_pkg::CfgOpen;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    errors      = 0;
    in_accepts  = 0;
    typed_valid = 1'b0;
    typed_want  = '0;
    hold_req    = 1'b0;
    calm        = 1'b0;
    cycles      = 0;
    len_a       = 0;
    len_b       = 0;
    fetch_idx   = 0;
    drop_seen   = 1'b0;
    open_pen    = 10;
    ext_pen     = 1;
    for (n = 0; n < aggt_pkg::TabDepth; n++) subst_sh[n] = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Load every entry that the stimulus symbols can address.
    for (ra = 0; ra < 4; ra++) begin
      for (ca = 0; ca < 4; ca++) begin
        r.item           = make_item(aggt_pkg::KindLoad, 5'd0);
        r.item.table_row = set_sym(ra);
        r.item.table_col = set_sym(ca);
        send_item(r.item);
      end
    end

    // Directed table: after reset, extremes, reserved kinds, clear.
    none_res        = '0;
    none_res.status = aggt_pkg::StatNone;
    empty_res       = '0;
    r.typed = 1'b1; r.want = none_res;
    r.item = make_item(aggt_pkg::KindFetch, 5'd0); rows.push_back(r);
    r.want = empty_res;
    r.item = make_item(aggt_pkg::KindAlign, 5'd0); rows.push_back(r);
    r.want = none_res;
    r.item = make_item(aggt_pkg::KindFetch, 5'd0); rows.push_back(r);
    r.typed = 1'b0;
    r.item = make_item(aggt_pkg::KindLoad, 5'd0);
    r.item.table_row = 5'd31; r.item.table_col = 5'd0; r.item.table_score = -8'sd128;
    rows.push_back(r);
    r.item.table_row = 5'd0; r.item.table_col = 5'd31; r.item.table_score = 8'sd127;
    rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAppA, 5'd31); rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAppB, 5'd0);  rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAppA, 5'd0);  rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAppB, 5'd31); rows.push_back(r);
    r.item = make_item(3'd6, 5'd7);      rows.push_back(r);
    r.item = make_item(3'd7, 5'd9);      rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAlign, 5'd0); rows.push_back(r);
    for (n = 0; n < 4; n++) begin
      r.item = make_item(aggt_pkg::KindFetch, 5'd0); rows.push_back(r);
    end
    r.item = make_item(aggt_pkg::KindClear, 5'd0); rows.push_back(r);
    r.typed = 1'b1; r.want = empty_res;
    r.item = make_item(aggt_pkg::KindAlign, 5'd0); rows.push_back(r);
    r.typed = 1'b0;
    r.item = make_item(aggt_pkg::KindAppB, 5'd21); rows.push_back(r);
    r.item = make_item(aggt_pkg::KindAlign, 5'd0); rows.push_back(r);
    r.item = make_item(aggt_pkg::KindFetch, 5'd0); rows.push_back(r);
    r.item = make_item(aggt_pkg::KindFetch, 5'd0); rows.push_back(r);

    foreach (rows[i]) begin
      typed_valid = rows[i].typed;
      typed_want  = rows[i].want;
      send_item(rows[i].item);
    end
    typed_valid = 1'b0;

    // Random phases across gap settings, extremes included.
    open_set = '{8'd10, 8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom)};
    ext_set  = '{8'd1, 8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom)};
    for (ph = 0; ph < 6; ph++) begin
      quiesce();
      write_gap_reg(aggt_pkg::CfgOpen, open_set[ph]);
      write_gap_reg(aggt_pkg::CfgExt, ext_set[ph]);
      calm = (ph == 2);
      if (ph == 3) begin
        // long output stall while the sender keeps offering work
        run_alignment(4, 3);
        send_item(make_item(aggt_pkg::KindAlign, 5'd0));
        hold_req = 1'b1;
        for (n = 0; n < 6; n++) send_item(make_item(aggt_pkg::KindFetch, 5'd0));
      end
      if ($urandom_range(99) < 25) send_noise();
      run_alignment($urandom_range(0, 4), $urandom_range(0, 4));
      if ($urandom_range(1)) send_noise();
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles * 4) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
